>>> hw/rtl/lpht_pkg.sv
// Package for the linear probing hash table: field widths, operation,
// status and slot tag codes, and the stored slot record type.
// Depends on nothing; every other file of the block but lpht_ram imports it.
package lpht_pkg;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 31;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;
    localparam int TAG_W    = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_MISSING = 2'd2
    } status_t;

    typedef enum logic [TAG_W-1:0] {
        TAG_EMPTY   = 2'd0,
        TAG_LIVE    = 2'd1,
        TAG_DELETED = 2'd2,
        TAG_UNUSED  = 2'd3
    } tag_t;

    typedef struct packed {
        tag_t              tag;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] data;
    } slot_t;

endpackage

>>> hw/rtl/lpht_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No package dependency.
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/lpht_mod.sv
// Serial remainder unit: key modulo slot count, one quotient bit per cycle.
// Depends on lpht_pkg for the key width.
module lpht_mod #(
    parameter int DIV_W = 11
) (
    input  logic                      clk,
    input  logic                      rstn,
    input  logic                      start,
    input  logic [lpht_pkg::KEY_W-1:0] dividend,
    input  logic [DIV_W-1:0]          divisor,
    output logic                      done,
    output logic [DIV_W-1:0]          remainder
);
    import lpht_pkg::*;

    localparam int CNT_W = $clog2(KEY_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0] dvd_reg, dvd_next;
    logic [DIV_W-1:0] div_reg, div_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W:0]   shifted;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[KEY_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(KEY_W - 1);
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            // restoring step: bring in one dividend bit, subtract if it fits
            if (shifted >= {1'b0, div_reg}) begin
                rem_next = DIV_W'(shifted - {1'b0, div_reg});
            end else begin
                rem_next = DIV_W'(shifted);
            end
            dvd_next = {dvd_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> hw/rtl/linear_probe_hash_table_top.sv
// Linear probing hash table, top level: sequencer, slot RAM and remainder unit.
// An accepted item has its home slot computed by the serial remainder unit, then probes slots
// in turn (a RAM read, then a check) until it succeeds or has swept every slot in use.
// Inserts refused on accept and operation 3 go straight to the result; one item in flight.
// Reset: a clearing pass writes every slot empty, with s_ready low throughout.
// Depends on lpht_pkg, lpht_ram and lpht_mod.
module linear_probe_hash_table_top #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lpht_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lpht_pkg::OP_W-1:0]     s_operation,
    input  logic [lpht_pkg::KEY_W-1:0]    s_key,
    input  logic [lpht_pkg::DATA_W-1:0]   s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lpht_pkg::STATUS_W-1:0] m_status,
    output logic [lpht_pkg::DATA_W-1:0]   m_payload_out,
    output logic [lpht_pkg::CFG_W-1:0]    m_entry_count
);
    import lpht_pkg::*;

    // slot index width, and a count width that can hold TABLE_SLOTS itself
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int NW     = SLOT_W + 1;
    localparam int EW     = (NW > CFG_W) ? NW : CFG_W;
    localparam logic [EW-1:0] SLOTS_E = EW'(TABLE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_HASH  = 6'b000100,
        ST_PROBE = 6'b001000,
        ST_CHECK = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    cfg_reg;
    op_t                 op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [DATA_W-1:0]   pay_reg, pay_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic [NW-1:0]       seen_reg, seen_next;
    logic [NW-1:0]       live_reg, live_next;
    logic [SLOT_W-1:0]   clr_reg, clr_next;
    status_t             res_status_reg, res_status_next;
    logic [DATA_W-1:0]   res_data_reg, res_data_next;
    logic                m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;
    logic [CFG_W-1:0]    m_count_reg, m_count_next;

    logic [EW-1:0]       cfg_ext;
    logic [NW-1:0]       eff_n;
    logic [NW-1:0]       seen_inc;
    logic [NW-1:0]       pos_inc;
    logic                mod_start;
    logic                mod_done;
    logic [NW-1:0]       mod_rem;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    slot_t               ram_wdata;
    slot_t               rd_slot;
    logic [$bits(slot_t)-1:0] ram_rdata;

    // configuration register: the user must write it only while the block is idle; not enforced here
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_wr_en) begin
            cfg_reg <= cfg_wr_data;
        end
    end

    // effective slot count: zero acts as one, clamp to the table size
    always_comb begin
        cfg_ext = EW'(cfg_reg);
        if (cfg_ext == '0) begin
            eff_n = NW'(1);
        end else if (cfg_ext > SLOTS_E) begin
            eff_n = NW'(SLOTS_E);
        end else begin
            eff_n = NW'(cfg_ext);
        end
    end

    assign rd_slot  = slot_t'(ram_rdata);
    assign seen_inc = seen_reg + 1'b1;
    assign pos_inc  = {1'b0, pos_reg} + 1'b1;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        n_next          = n_reg;
        pos_next        = pos_reg;
        seen_next       = seen_reg;
        live_next       = live_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_data_next     = m_data_reg;
        m_count_next    = m_count_reg;
        mod_start       = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = '{tag: TAG_LIVE, key: key_reg, data: pay_reg};

        unique case (state_reg)
            ST_CLEAR: begin
                // sweep every slot to empty after reset
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '{tag: TAG_EMPTY, key: '0, data: '0};
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    op_next         = op_t'(s_operation);
                    key_next        = s_key;
                    pay_next        = s_payload;
                    n_next          = eff_n;
                    res_data_next   = '0;
                    res_status_next = STAT_OK;
                    if (op_t'(s_operation) == OP_NONE) begin
                        state_next = ST_DONE;
                    end else if (op_t'(s_operation) == OP_INSERT && live_reg >= eff_n) begin
                        res_status_next = STAT_FULL;
                        state_next      = ST_DONE;
                    end else begin
                        mod_start  = 1'b1;
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                // hold until the home slot is known
                if (mod_done) begin
                    pos_next   = SLOT_W'(mod_rem);
                    seen_next  = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                // RAM read of pos_reg is in flight
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                state_next = ST_DONE;
                if (op_reg == OP_INSERT && rd_slot.tag != TAG_LIVE) begin
                    // first empty or deleted slot takes the record
                    ram_we    = 1'b1;
                    live_next = live_reg + 1'b1;
                end else if (op_reg != OP_INSERT && rd_slot.tag == TAG_EMPTY) begin
                    res_status_next = STAT_MISSING;
                end else if (op_reg != OP_INSERT && rd_slot.tag == TAG_LIVE
                             && rd_slot.key == key_reg) begin
                    if (op_reg == OP_DELETE) begin
                        // leave a tombstone so later probes keep walking
                        ram_we    = 1'b1;
                        ram_wdata = '{tag: TAG_DELETED, key: rd_slot.key,
                                      data: rd_slot.data};
                        if (live_reg != '0) begin
                            live_next = live_reg - 1'b1;
                        end
                    end else begin
                        res_data_next = rd_slot.data;
                    end
                end else if (seen_inc >= n_reg) begin
                    // one full sweep without success
                    res_status_next = (op_reg == OP_INSERT) ? STAT_FULL : STAT_MISSING;
                end else begin
                    // advance with wrap past the last slot in use
                    seen_next  = seen_inc;
                    pos_next   = (pos_inc >= n_reg) ? '0 : SLOT_W'(pos_inc);
                    state_next = ST_PROBE;
                end
            end
            ST_DONE: begin
                // load the output register once it is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_data_next   = res_data_reg;
                    m_count_next  = CFG_W'(live_reg);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            live_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        n_reg          <= n_next;
        pos_reg        <= pos_next;
        seen_reg       <= seen_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        m_status_reg   <= m_status_next;
        m_data_reg     <= m_data_next;
        m_count_reg    <= m_count_next;
    end

    lpht_mod #(
        .DIV_W (NW)
    ) u_mod (
        .clk       (aclk),
        .rstn      (aresetn),
        .start     (mod_start),
        .dividend  (s_key),
        .divisor   (eff_n),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    lpht_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (pos_reg),
        .rd_data (ram_rdata)
    );

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_payload_out = m_data_reg;
    assign m_entry_count = m_count_reg;

`ifndef SYNTHESIS
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= NW'(TABLE_SLOTS))
        else $error("live count above table size");

    a_seen_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CHECK) |-> (seen_reg < n_reg))
        else $error("probe walk went past one sweep");

    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> ({1'b0, pos_reg} < n_reg))
        else $error("probe slot outside slots in use");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start work");

    a_hash_probe: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HASH && mod_done) |=> (state_reg == ST_PROBE))
        else $error("home slot ready but no probe issued");
`endif

endmodule

>>> sim/lpht_table_checker.sv
// Reply checker for the linear probing hash table: mirrors the slot store and
// the slot-count register, predicts each reply and compares it field by field.
// Depends on lpht_pkg; instantiated by tb beside the block.
module lpht_table_checker #(
    parameter int TABLE_SLOTS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lpht_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [lpht_pkg::OP_W-1:0]     s_operation,
    input  logic [lpht_pkg::KEY_W-1:0]    s_key,
    input  logic [lpht_pkg::DATA_W-1:0]   s_payload,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [lpht_pkg::STATUS_W-1:0] m_status,
    input  logic [lpht_pkg::DATA_W-1:0]   m_payload_out,
    input  logic [lpht_pkg::CFG_W-1:0]    m_entry_count,
    output int                            fail_count,
    output int                            outstanding,
    output int                            ok_replies,
    output int                            full_replies,
    output int                            missing_replies
);
    timeunit 1ns;
    timeprecision 1ps;
    import lpht_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] payload;
        logic [CFG_W-1:0]  count;
    } reply_t;

    tag_t              tag_mem  [TABLE_SLOTS];
    logic [KEY_W-1:0]  key_mem  [TABLE_SLOTS];
    logic [DATA_W-1:0] data_mem [TABLE_SLOTS];
    int unsigned       live_records;
    logic [CFG_W-1:0]  slots_reg;
    reply_t            pending_replies[$];

    function automatic int unsigned usable_slots();
        if (slots_reg == '0)
            return 1;
        if (slots_reg > TABLE_SLOTS)
            return TABLE_SLOTS;
        return slots_reg;
    endfunction

    function automatic int unsigned next_pos(int unsigned pos, int unsigned n);
        return (pos + 1 >= n) ? 0 : pos + 1;
    endfunction

    // slot of the first live match within one sweep, n when none is reachable
    function automatic int unsigned locate_key(logic [KEY_W-1:0] k, int unsigned n);
        int unsigned pos;
        int unsigned seen;
        pos = k % n;
        for (seen = 0; seen < n; seen++) begin
            if (tag_mem[pos] == TAG_EMPTY)
                return n;
            if (tag_mem[pos] == TAG_LIVE && key_mem[pos] == k)
                return pos;
            pos = next_pos(pos, n);
        end
        return n;
    endfunction

    // apply one operation to the mirrored table and return its reply
    function automatic reply_t probe_table(op_t op, logic [KEY_W-1:0] k,
                                           logic [DATA_W-1:0] d);
        reply_t      r;
        int unsigned n;
        int unsigned pos;
        int unsigned seen;
        n = usable_slots();
        r.status = STAT_OK;
        r.payload = '0;
        case (op)
            OP_INSERT: begin
                if (live_records >= n) begin
                    r.status = STAT_FULL;
                end else begin
                    pos = k % n;
                    seen = 0;
                    while (seen < n && tag_mem[pos] == TAG_LIVE) begin
                        pos = next_pos(pos, n);
                        seen++;
                    end
                    if (seen >= n) begin
                        r.status = STAT_FULL;
                    end else begin
                        tag_mem[pos] = TAG_LIVE;
                        key_mem[pos] = k;
                        data_mem[pos] = d;
                        live_records++;
                    end
                end
            end
            OP_DELETE: begin
                pos = locate_key(k, n);
                if (pos >= n) begin
                    r.status = STAT_MISSING;
                end else begin
                    tag_mem[pos] = TAG_DELETED;
                    if (live_records > 0)
                        live_records--;
                end
            end
            OP_SEARCH: begin
                pos = locate_key(k, n);
                if (pos >= n)
                    r.status = STAT_MISSING;
                else
                    r.payload = data_mem[pos];
            end
            default: ;
        endcase
        r.count = live_records[CFG_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin : watch_channels
        reply_t want;
        int     errs;
        int     i;
        errs = 0;
        if (!aresetn) begin
            for (i = 0; i < TABLE_SLOTS; i++)
                tag_mem[i] = TAG_EMPTY;
            live_records = 0;
            slots_reg = CFG_RESET;
            pending_replies.delete();
        end else begin
            if (cfg_wr_en)
                slots_reg = cfg_wr_data;
            if (s_valid && s_ready)
                pending_replies.push_back(probe_table(op_t'(s_operation), s_key, s_payload));
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    $error("reply with no item pending: status %0d payload_out %h entry_count %0d",
                           m_status, m_payload_out, m_entry_count);
                    errs++;
                end else begin
                    want = pending_replies.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        errs++;
                    end
                    if (m_payload_out !== want.payload) begin
                        $error("payload_out: expected %h, got %h", want.payload, m_payload_out);
                        errs++;
                    end
                    if (m_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, m_entry_count);
                        errs++;
                    end
                    case (want.status)
                        STAT_OK:   ok_replies <= ok_replies + 1;
                        STAT_FULL: full_replies <= full_replies + 1;
                        default:   missing_replies <= missing_replies + 1;
                    endcase
                end
            end
        end
        fail_count <= fail_count + errs;
        outstanding <= pending_replies.size();
    end

endmodule

>>> sim/tb.sv
// Testbench top for the linear probing hash table: clock, reset, stimulus and
// the verdict. Depends on lpht_pkg, linear_probe_hash_table_top and lpht_table_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpht_pkg::*;

    localparam int TABLE_SLOTS = 1024;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 102;
    // worst case per item: full sweep plus remainder, a long reply stall and a
    // sender gap; taken three times over, plus the clearing pass after reset
    localparam longint CYCLE_LIMIT = 64'd3 * 1300 * (34 + 2 * TABLE_SLOTS + 80)
                                     + 2 * TABLE_SLOTS + 2000;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic [OP_W-1:0]     s_operation = '0;
    logic [KEY_W-1:0]    s_key       = '0;
    logic [DATA_W-1:0]   s_payload   = '0;
    logic                m_ready     = 1'b0;
    logic                s_ready;
    logic                m_valid;
    logic [STATUS_W-1:0] m_status;
    logic [DATA_W-1:0]   m_payload_out;
    logic [CFG_W-1:0]    m_entry_count;

    int fail_count;
    int outstanding;
    int ok_replies;
    int full_replies;
    int missing_replies;

    // calm: no idling on either side while set
    bit               calm = 1'b0;
    longint           cycles = 0;
    int               items_sent = 0;
    int unsigned      phase_slots [PHASES] = '{1, 0, 2, 3, 5, 16, 33, 64, 200, 1024, 2047, 7};
    logic [KEY_W-1:0] recent_keys[$];

    always #5ns aclk = ~aclk;

    linear_probe_hash_table_top #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_key        (s_key),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_payload_out(m_payload_out),
        .m_entry_count(m_entry_count)
    );

    lpht_table_checker #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) table_watch (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_key          (s_key),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_payload_out  (m_payload_out),
        .m_entry_count  (m_entry_count),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .ok_replies     (ok_replies),
        .full_replies   (full_replies),
        .missing_replies(missing_replies)
    );

    // Offer one item: idle a random number of cycles first (valid low), then
    // hold valid and payload until the handshake. Valid is left high on
    // return so back-to-back items never lower and raise it in one step.
    task automatic send_item(input op_t op, input logic [KEY_W-1:0] k,
                             input logic [DATA_W-1:0] d);
        while (!calm && $urandom_range(0, 99) < 23) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_key <= k;
        s_payload <= d;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        items_sent++;
    endtask

    // Drop valid and hold off until every predicted reply has come back.
    // The checker's count is registered, so step the clock before reading it.
    task automatic wait_for_replies();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // Write the slot-count register; only called with the block idle.
    task automatic set_slot_count(input logic [CFG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // One random item. Half the keys come back from recent inserts so deletes
    // and searches hit; small keys crowd the home slots and force long probe
    // walks; the rest are full-range keys to toggle every key bit.
    task automatic send_random_item(input int unsigned n);
        int unsigned      roll;
        int unsigned      pick;
        op_t              op;
        logic [KEY_W-1:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            op = OP_INSERT;
        else if (roll < 65)
            op = OP_DELETE;
        else if (roll < 95)
            op = OP_SEARCH;
        else
            op = OP_NONE;
        pick = $urandom_range(0, 99);
        if (pick < 50 && recent_keys.size() != 0)
            k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else if (pick < 70)
            k = KEY_W'($urandom());
        else
            k = KEY_W'($urandom_range(0, 4 * n));
        if (op == OP_INSERT) begin
            recent_keys.push_back(k);
            if (recent_keys.size() > 64)
                void'(recent_keys.pop_front());
        end
        send_item(op, k, $urandom());
    endtask

    // Result side: random stalls, except in the calm phase. Once, after a few
    // hundred replies, hold ready low for a long stretch so the block backs
    // up and stalls its input while the sender keeps offering items.
    initial begin : reply_sink
        int taken;
        bit held;
        taken = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                taken++;
            if (!held && taken == 400) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (300) @(posedge aclk);
            end else begin
                m_ready <= calm || ($urandom_range(0, 99) >= 23);
            end
        end
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d replies still pending", cycles, outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        int p;
        int i;
        int unsigned eff;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset slot count (1024): miss on an empty table,
        // extreme keys and payloads, the unused operation, delete twice.
        send_item(OP_SEARCH, 31'd5, 32'h0);
        send_item(OP_INSERT, 31'd0, 32'h0);
        send_item(OP_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_SEARCH, 31'h7FFF_FFFF, 32'h0);
        send_item(OP_SEARCH, 31'd0, 32'hFFFF_FFFF);
        send_item(OP_NONE, KEY_W'($urandom()), $urandom());
        send_item(OP_DELETE, 31'd0, 32'h0);
        send_item(OP_DELETE, 31'd0, 32'h0);

        // Four slots, with the top-key record stranded beyond them: colliding
        // inserts, refusal on a full count, probing past a tombstone, and a
        // search that sweeps every slot without finding an empty one.
        wait_for_replies();
        set_slot_count(11'd4);
        send_item(OP_INSERT, 31'd4, $urandom());
        send_item(OP_INSERT, 31'd8, $urandom());
        send_item(OP_INSERT, 31'd13, $urandom());
        send_item(OP_INSERT, 31'd9, $urandom());
        send_item(OP_DELETE, 31'd8, 32'h0);
        send_item(OP_SEARCH, 31'd13, 32'h0);
        send_item(OP_SEARCH, 31'd12, 32'h0);
        send_item(OP_INSERT, 31'd3, $urandom());
        send_item(OP_SEARCH, 31'd12, 32'h0);
        send_item(OP_INSERT, 31'd12, $urandom());

        // Oversized count clamps to the full table: the stranded record is
        // reachable again.
        wait_for_replies();
        set_slot_count(11'd2047);
        send_item(OP_SEARCH, 31'h7FFF_FFFF, 32'h0);
        send_item(OP_DELETE, 31'h7FFF_FFFF, 32'h0);

        // Count zero acts as one slot.
        wait_for_replies();
        set_slot_count(11'd0);
        send_item(OP_INSERT, 31'd1, $urandom());
        send_item(OP_SEARCH, 31'd4, 32'h0);
        send_item(OP_DELETE, 31'd4, 32'h0);
        send_item(OP_SEARCH, 31'd4, 32'h0);
        send_item(OP_INSERT, 31'd7, $urandom());

        // Delete the leftover keys before the random part.
        wait_for_replies();
        set_slot_count(11'd1024);
        send_item(OP_DELETE, 31'd13, 32'h0);
        send_item(OP_DELETE, 31'd3, 32'h0);

        // Random part: one slot count per phase, records carried across.
        for (p = 0; p < PHASES; p++) begin
            wait_for_replies();
            set_slot_count(CFG_W'(phase_slots[p]));
            eff = (phase_slots[p] == 0) ? 1 :
                  (phase_slots[p] > TABLE_SLOTS) ? TABLE_SLOTS : phase_slots[p];
            calm = (p == 5);
            for (i = 0; i < PHASE_ITEMS; i++) begin
                // pause the sender mid-phase until the block drains
                if (p == 8 && i == PHASE_ITEMS / 2)
                    wait_for_replies();
                send_random_item(eff);
            end
        end
        calm = 1'b0;

        wait_for_replies();
        repeat (50) @(posedge aclk);

        $display("ran %0d items over %0d slot-count settings plus directed cases",
                 items_sent, PHASES);
        $display("replies: %0d ok, %0d refused as full, %0d not found",
                 ok_replies, full_replies, missing_replies);
        if (fail_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
